// ===== sv/lfps_pkg.sv =====
`default_nettype none

package lfps_pkg;

   localparam int RING_DEPTH        = 64;
   localparam int POS_W             = 6;
   localparam int WORD_W            = 64;
   localparam int HALF_W            = 32;
   localparam int WARMUP_ROUNDS_DEF = 32;
   localparam int UPC_W             = 5;

   localparam logic [WORD_W-1:0] SCRAMBLE_MUL = 64'd2685821657736338717;
   localparam logic [WORD_W-1:0] GOLDEN_STEP  = 64'h9E3779B97F4A7C15;
   localparam logic [WORD_W-1:0] CHAOS_INIT   = 64'hDEADBEEFDEADBEEF;

   localparam int SHIFT_A = 52;
   localparam int SHIFT_B = 37;
   localparam int ROT_C   = 12;

   localparam logic [POS_W-1:0] LAG_NONE = 6'd0;
   localparam logic [POS_W-1:0] LAG_A    = 6'd61;
   localparam logic [POS_W-1:0] LAG_B    = 6'd60;
   localparam logic [POS_W-1:0] LAG_C    = 6'd46;
   localparam logic [POS_W-1:0] LAG_D    = 6'd45;

   localparam logic [3:0] OP_NOP          = 4'd0;
   localparam logic [3:0] OP_POS_INC      = 4'd1;
   localparam logic [3:0] OP_ACC_LD_RD    = 4'd2;
   localparam logic [3:0] OP_ACC_ADD_RD   = 4'd3;
   localparam logic [3:0] OP_SUM          = 4'd4;
   localparam logic [3:0] OP_ACC_LD_PROD  = 4'd5;
   localparam logic [3:0] OP_ACC_ADD_PROD = 4'd6;
   localparam logic [3:0] OP_XS37         = 4'd7;
   localparam logic [3:0] OP_OUT          = 4'd8;
   localparam logic [3:0] OP_SEED_INIT    = 4'd9;
   localparam logic [3:0] OP_X_STEP       = 4'd10;
   localparam logic [3:0] OP_A_STEP       = 4'd11;
   localparam logic [3:0] OP_B_STEP       = 4'd12;
   localparam logic [3:0] OP_C_STEP       = 4'd13;
   localparam logic [3:0] OP_POS_CLR      = 4'd14;

   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_LL   = 2'd1;
   localparam logic [1:0] MUL_LH   = 2'd2;
   localparam logic [1:0] MUL_HL   = 2'd3;

   localparam logic [1:0] SEQ_NEXT = 2'd0;
   localparam logic [1:0] SEQ_LOOP = 2'd1;
   localparam logic [1:0] SEQ_END  = 2'd2;

   localparam logic [UPC_W-1:0] NEXT_ENTRY = 5'd0;
   localparam logic [UPC_W-1:0] SEED_ENTRY = 5'd14;
   localparam logic [UPC_W-1:0] ROUND_LOOP = 5'd15;

   typedef struct packed {
      logic [3:0]       op;
      logic [1:0]       mul;
      logic [POS_W-1:0] lag;
      logic [1:0]       seq;
      logic [UPC_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic rounds_left;
   } stat_type;

   function automatic ctl_type ucode(input logic [UPC_W-1:0] upc);
      ctl_type w;
      w = '{op: OP_NOP, mul: MUL_NONE, lag: LAG_NONE, seq: SEQ_END, target: NEXT_ENTRY};
      case (upc)
         5'd0: w = '{OP_POS_INC, MUL_NONE, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd1: w = '{OP_NOP, MUL_NONE, LAG_A, SEQ_NEXT, NEXT_ENTRY};
         5'd2: w = '{OP_ACC_LD_RD, MUL_NONE, LAG_B, SEQ_NEXT, NEXT_ENTRY};
         5'd3: w = '{OP_ACC_ADD_RD, MUL_NONE, LAG_C, SEQ_NEXT, NEXT_ENTRY};
         5'd4: w = '{OP_ACC_ADD_RD, MUL_NONE, LAG_D, SEQ_NEXT, NEXT_ENTRY};
         5'd5: w = '{OP_SUM, MUL_NONE, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd6: w = '{OP_NOP, MUL_LL, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd7: w = '{OP_ACC_LD_PROD, MUL_LH, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd8: w = '{OP_ACC_ADD_PROD, MUL_HL, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd9: w = '{OP_XS37, MUL_NONE, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd10: w = '{OP_NOP, MUL_LL, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd11: w = '{OP_ACC_LD_PROD, MUL_LH, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd12: w = '{OP_ACC_ADD_PROD, MUL_HL, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd13: w = '{OP_OUT, MUL_NONE, LAG_NONE, SEQ_END, NEXT_ENTRY};
         5'd14: w = '{OP_SEED_INIT, MUL_NONE, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd15: w = '{OP_X_STEP, MUL_NONE, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd16: w = '{OP_A_STEP, MUL_NONE, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd17: w = '{OP_B_STEP, MUL_NONE, LAG_NONE, SEQ_NEXT, NEXT_ENTRY};
         5'd18: w = '{OP_C_STEP, MUL_NONE, LAG_NONE, SEQ_LOOP, ROUND_LOOP};
         5'd19: w = '{OP_POS_CLR, MUL_NONE, LAG_NONE, SEQ_END, NEXT_ENTRY};
         default: w = '{OP_NOP, MUL_NONE, LAG_NONE, SEQ_END, NEXT_ENTRY};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== sv/lfps_seq.sv =====
`default_nettype none

module lfps_seq
   import lfps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_operation,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire stat_type stat,
   output ctl_type      ctl,
   output logic         step_en,
   output logic         accept
);

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             stall;

   assign ctl       = ucode(upc_ff);
   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !busy_ff;
   assign stall     = (ctl.op == OP_OUT) && rsp_valid_ff && !rsp_ready;
   assign step_en   = busy_ff && !stall;

   always_comb begin
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         upc_in  = req_operation ? SEED_ENTRY : NEXT_ENTRY;
      end else if (step_en) begin
         if (ctl.op == OP_OUT) begin
            rsp_valid_in = 1'b1;
         end
         case (ctl.seq)
            SEQ_NEXT: upc_in = upc_ff + 1'b1;
            SEQ_LOOP: upc_in = stat.rounds_left ? ctl.target : upc_ff + 1'b1;
            SEQ_END:  busy_in = 1'b0;
            default:  busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= NEXT_ENTRY;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("sequencer not busy after a transfer was taken");

   a_seed_entry: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation |=> upc_ff == SEED_ENTRY)
      else $error("reseed did not start at its entry step");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && stall |=> $stable(upc_ff) && busy_ff)
      else $error("step counter moved while the result slot was full");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && ctl.seq == SEQ_END |=> !busy_ff)
      else $error("sequencer stayed busy after the last step");

endmodule

`default_nettype wire

// ===== sv/lfps_dp.sv =====
`default_nettype none

module lfps_dp
   import lfps_pkg::*;
#(
   parameter int WARMUP_ROUNDS = WARMUP_ROUNDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_type           ctl,
   input  wire logic              step_en,
   input  wire logic              seed_load,
   input  wire logic [WORD_W-1:0] seed_value,
   output stat_type               stat,
   output logic [WORD_W-1:0]      random_word
);

   localparam int TOTAL_ROUNDS = WARMUP_ROUNDS + RING_DEPTH;
   localparam int RND_W        = $clog2(TOTAL_ROUNDS);

   logic [WORD_W-1:0] ring_mem [RING_DEPTH];

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [RING_DEPTH-1:0] vld_ff, vld_in;
   logic [WORD_W-1:0]     rdata_ff;
   logic                  rvld_ff;
   logic [WORD_W-1:0]     acc_ff, acc_in;
   logic [WORD_W-1:0]     mop_ff, mop_in;
   logic [WORD_W-1:0]     prod_ff, prod_in;
   logic [WORD_W-1:0]     x_ff, x_in, a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [RND_W-1:0]      rnd_ff, rnd_in;
   logic [WORD_W-1:0]     seed_ff, seed_in;
   logic [WORD_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0]  rd_addr, wr_addr, fill_idx;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_word, sum, tsum, c_new, fill_word;
   logic [HALF_W-1:0] m_a, m_b;
   logic [WORD_W-1:0] mul_p;

   assign rd_addr  = pos_ff - ctl.lag;
   assign rd_word  = rvld_ff ? rdata_ff : '0;
   assign sum      = acc_ff + rd_word;
   assign tsum     = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
   assign c_new    = (c_ff + {b_ff[WORD_W-ROT_C-1:0], b_ff[WORD_W-1:WORD_W-ROT_C]}) ^ a_ff;
   assign fill_idx = POS_W'(rnd_ff - RND_W'(WARMUP_ROUNDS));

   always_comb begin
      fill_word = c_new ^ b_ff;
      if (fill_idx == POS_W'(0)) begin
         fill_word[0] = 1'b1;
      end else if (fill_idx == POS_W'(1)) begin
         fill_word = '0;
      end
   end

   always_comb begin
      m_a = mop_ff[HALF_W-1:0];
      m_b = SCRAMBLE_MUL[HALF_W-1:0];
      case (ctl.mul)
         MUL_LH: m_b = SCRAMBLE_MUL[WORD_W-1:HALF_W];
         MUL_HL: m_a = mop_ff[WORD_W-1:HALF_W];
         default: m_a = mop_ff[HALF_W-1:0];
      endcase
   end

   assign mul_p = {{HALF_W{1'b0}}, m_a} * {{HALF_W{1'b0}}, m_b};

   always_comb begin
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      mop_in      = mop_ff;
      prod_in     = prod_ff;
      x_in        = x_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      rnd_in      = rnd_ff;
      rsp_data_in = rsp_data_ff;
      seed_in     = seed_load ? seed_value : seed_ff;
      wr_en       = 1'b0;
      wr_addr     = pos_ff;
      wr_data     = sum;
      if (step_en) begin
         if (ctl.mul != MUL_NONE) begin
            prod_in = mul_p;
         end
         case (ctl.op)
            OP_POS_INC:      pos_in = pos_ff + 1'b1;
            OP_ACC_LD_RD:    acc_in = rd_word;
            OP_ACC_ADD_RD:   acc_in = sum;
            OP_SUM: begin
               wr_en  = 1'b1;
               mop_in = sum ^ (sum >> SHIFT_A);
            end
            OP_ACC_LD_PROD:  acc_in = prod_ff;
            OP_ACC_ADD_PROD: acc_in = tsum;
            OP_XS37:         mop_in = tsum ^ (tsum >> SHIFT_B);
            OP_OUT:          rsp_data_in = tsum;
            OP_SEED_INIT: begin
               x_in   = '0;
               a_in   = seed_ff;
               b_in   = ~seed_ff;
               c_in   = CHAOS_INIT;
               rnd_in = '0;
            end
            OP_X_STEP:       x_in = x_ff + GOLDEN_STEP;
            OP_A_STEP:       a_in = a_ff ^ c_ff ^ x_ff;
            OP_B_STEP:       b_in = b_ff + a_ff;
            OP_C_STEP: begin
               c_in   = c_new;
               rnd_in = rnd_ff + 1'b1;
               if (rnd_ff >= RND_W'(WARMUP_ROUNDS)) begin
                  wr_en   = 1'b1;
                  wr_addr = fill_idx;
                  wr_data = fill_word;
               end
            end
            OP_POS_CLR:      pos_in = '0;
            default:         pos_in = pos_ff;
         endcase
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   assign stat.rounds_left = (rnd_ff != RND_W'(TOTAL_ROUNDS - 1));
   assign random_word      = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         vld_ff  <= vld_in;
         rvld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      mop_ff      <= mop_in;
      prod_ff     <= prod_in;
      x_ff        <= x_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      rnd_ff      <= rnd_in;
      seed_ff     <= seed_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== sv/lagged_fibonacci_prng_scrambled_top.sv =====
// A next request takes 14 sequencer steps, and the block takes no new request until it has
// finished the last one; the steps are set by four tap reads through the single ring read port
// and six 32x32 partial products through the one shared multiplier.
// A reseed runs the warm-up rounds, fills the 64 ring words and gives no result.
// Reset marks all 64 ring words invalid so that they read as zero, and clears the position.
`default_nettype none

module lagged_fibonacci_prng_scrambled_top
   import lfps_pkg::*;
#(
   parameter int WARMUP_ROUNDS = WARMUP_ROUNDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_operation,
   input  wire logic [WORD_W-1:0] req_seed_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [WORD_W-1:0]      rsp_random_word
);

   ctl_type  ctl;
   stat_type stat;
   logic     step_en;
   logic     accept;

   lfps_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .ctl           (ctl),
      .step_en       (step_en),
      .accept        (accept)
   );

   lfps_dp #(
      .WARMUP_ROUNDS (WARMUP_ROUNDS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .step_en     (step_en),
      .seed_load   (accept),
      .seed_value  (req_seed_value),
      .stat        (stat),
      .random_word (rsp_random_word)
   );

endmodule

`default_nettype wire

// ===== verif/lfps_tb_pkg.sv =====
`timescale 1ns / 1ps

package lfps_tb_pkg;

   localparam logic OP_NEXT   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

endpackage

// ===== verif/lfps_checker.sv =====
`timescale 1ns / 1ps

module lfps_checker
   import lfps_pkg::*;
   import lfps_tb_pkg::*;
#(
   parameter int WARMUP = WARMUP_ROUNDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic              req_operation,
   input  wire logic [WORD_W-1:0] req_seed_value,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [WORD_W-1:0] rsp_random_word,
   output int                     mismatches,
   output int                     awaiting
);

   logic [WORD_W-1:0] lag_words [RING_DEPTH];
   logic [POS_W-1:0]  head;
   logic [WORD_W-1:0] expected_words [$];

   function automatic logic [WORD_W-1:0] rotl_c(input logic [WORD_W-1:0] v);
      return (v << ROT_C) | (v >> (WORD_W - ROT_C));
   endfunction

   function automatic logic [WORD_W-1:0] lagged(input logic [POS_W-1:0] lag);
      logic [POS_W-1:0] ix;
      ix = head - lag;
      return lag_words[ix];
   endfunction

   task automatic refill_ring(input logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] x, a, b, c;
      int r;
      x = '0;
      a = seed;
      b = ~seed;
      c = CHAOS_INIT;
      for (r = 0; r < WARMUP + RING_DEPTH; r++) begin
         x = x + GOLDEN_STEP;
         a = a ^ c ^ x;
         b = b + a;
         c = (c + rotl_c(b)) ^ a;
         if (r >= WARMUP) begin
            lag_words[r - WARMUP] = c ^ b;
         end
      end
      lag_words[0][0] = 1'b1;
      lag_words[1] = '0;
      head = '0;
   endtask

   task automatic advance_ring(output logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] u;
      head = head + 1'b1;
      u = lagged(LAG_A) + lagged(LAG_B) + lagged(LAG_C) + lagged(LAG_D);
      lag_words[head] = u;
      u = u ^ (u >> SHIFT_A);
      u = u * SCRAMBLE_MUL;
      u = u ^ (u >> SHIFT_B);
      u = u * SCRAMBLE_MUL;
      word = u;
   endtask

   // When both channels complete a transfer on the same edge, the request is
   // predicted first; its own result cannot arrive on that edge anyway.
   always @(posedge clock) begin : observe
      int i;
      logic [WORD_W-1:0] w;
      if (reset) begin
         for (i = 0; i < RING_DEPTH; i++) begin
            lag_words[i] = '0;
         end
         head = '0;
         expected_words.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_operation == OP_RESEED) begin
               refill_ring(req_seed_value);
            end else begin
               advance_ring(w);
               expected_words.push_back(w);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("random_word unexpected: expected none, got %h", rsp_random_word);
               mismatches = mismatches + 1;
            end else begin
               w = expected_words.pop_front();
               if (rsp_random_word !== w) begin
                  $error("random_word mismatch: expected %h, got %h", w, rsp_random_word);
                  mismatches = mismatches + 1;
               end
            end
         end
      end
      awaiting = expected_words.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import lfps_pkg::*;
   import lfps_tb_pkg::*;

   localparam int WARMUP        = WARMUP_ROUNDS_DEF;
   localparam int RANDOM_ITEMS  = 1030;
   localparam int LONG_HOLD     = 500;
   localparam int SETTLE_CYCLES = 4 * (WARMUP + RING_DEPTH) + 20;
   localparam int CYCLE_LIMIT   = 1200000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_operation;
   logic [WORD_W-1:0] req_seed_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [WORD_W-1:0] rsp_random_word;
   int                fail_count;
   int                awaiting;
   int                holds_wanted;
   int                send_calm;

   lagged_fibonacci_prng_scrambled_top #(
      .WARMUP_ROUNDS(WARMUP)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_random_word(rsp_random_word)
   );

   lfps_checker #(
      .WARMUP(WARMUP)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_random_word(rsp_random_word),
      .mismatches     (fail_count),
      .awaiting       (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   function automatic logic [WORD_W-1:0] random_seed();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_request(input logic op, input logic [WORD_W-1:0] seed);
      int gap;
      if (send_calm > 0) begin
         send_calm = send_calm - 1;
         gap = 0;
      end else begin
         gap = idle_length();
         if ($urandom_range(0, 39) == 0) begin
            send_calm = $urandom_range(10, 40);
         end
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_seed_value = seed;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin : receiver
      int stall_left;
      int recv_calm;
      int holds_served;
      stall_left = 0;
      recv_calm = 0;
      holds_served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_wanted > holds_served) begin
            holds_served = holds_served + 1;
            rsp_ready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
            if (recv_calm > 0) begin
               recv_calm = recv_calm - 1;
            end else begin
               stall_left = idle_length();
               if ($urandom_range(0, 39) == 0) begin
                  recv_calm = $urandom_range(20, 80);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles = cycles + 1;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int n;
      int pick;
      logic op;
      logic [WORD_W-1:0] seed;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_NEXT;
      req_seed_value = '0;
      holds_wanted = 0;
      send_calm = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Before any reseed the ring is all zero and every word comes out zero.
      send_request(OP_NEXT, '1);
      send_request(OP_NEXT, '0);
      send_request(OP_NEXT, random_seed());
      send_request(OP_RESEED, '0);
      repeat (4) send_request(OP_NEXT, random_seed());
      send_request(OP_RESEED, '1);
      repeat (4) send_request(OP_NEXT, '1);
      send_request(OP_RESEED, 64'h8000_0000_0000_0001);
      send_request(OP_NEXT, '0);
      send_request(OP_NEXT, 64'h8000_0000_0000_0000);
      send_request(OP_RESEED, random_seed());
      send_request(OP_RESEED, random_seed());
      repeat (2) send_request(OP_NEXT, random_seed());

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300 || n == 700) begin
            holds_wanted = holds_wanted + 1;
         end
         op = ($urandom_range(0, 79) == 0) ? OP_RESEED : OP_NEXT;
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            seed = '0;
         end else if (pick == 1) begin
            seed = '1;
         end else begin
            seed = random_seed();
         end
         send_request(op, seed);
      end
      req_valid = 1'b0;

      while (awaiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
